FILE: hdl/cpu_logic_load_transfer_unit_assert.svh
// ============================================================================
// Assertion macros for the load, logic and transfer unit
// Clocked implication checks used by the top-level RTL file of the block.
// ============================================================================
`ifndef CPU_LOGIC_LOAD_TRANSFER_UNIT_ASSERT_SVH
`define CPU_LOGIC_LOAD_TRANSFER_UNIT_ASSERT_SVH

// Checks that post holds in the cycle after pre.
`define CLLT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("cllt: next-cycle check failed");

// Checks that post holds in the same cycle as pre.
`define CLLT_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("cllt: same-cycle check failed");

`endif

FILE: hdl/cllt_pkg.sv
// ============================================================================
// Load, logic and transfer unit package
// Transaction types, architectural state and opcode constants.
// ============================================================================
package cllt_pkg;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic [7:0] status;
        logic [7:0] stack_ptr;
        logic       unknown_op;
    } t_out_item;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] status;
        logic [7:0] sp;
    } t_arch_state;

    localparam logic [7:0] SP_RESET = 8'hFF;

    localparam int unsigned FLAG_N = 7;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] OP_ORA_IMM = 8'h09;
    localparam logic [7:0] OP_ORA_ZP  = 8'h05;
    localparam logic [7:0] OP_ORA_ZPX = 8'h15;
    localparam logic [7:0] OP_ORA_ABS = 8'h0D;
    localparam logic [7:0] OP_ORA_ABX = 8'h1D;
    localparam logic [7:0] OP_ORA_ABY = 8'h19;
    localparam logic [7:0] OP_ORA_IZX = 8'h01;
    localparam logic [7:0] OP_ORA_IZY = 8'h11;

    localparam logic [7:0] OP_AND_IMM = 8'h29;
    localparam logic [7:0] OP_AND_ZP  = 8'h25;
    localparam logic [7:0] OP_AND_ZPX = 8'h35;
    localparam logic [7:0] OP_AND_ABS = 8'h2D;
    localparam logic [7:0] OP_AND_ABX = 8'h3D;
    localparam logic [7:0] OP_AND_ABY = 8'h39;
    localparam logic [7:0] OP_AND_IZX = 8'h21;
    localparam logic [7:0] OP_AND_IZY = 8'h31;

    localparam logic [7:0] OP_EOR_IMM = 8'h49;
    localparam logic [7:0] OP_EOR_ZP  = 8'h45;
    localparam logic [7:0] OP_EOR_ZPX = 8'h55;
    localparam logic [7:0] OP_EOR_ABS = 8'h4D;
    localparam logic [7:0] OP_EOR_ABX = 8'h5D;
    localparam logic [7:0] OP_EOR_ABY = 8'h59;
    localparam logic [7:0] OP_EOR_IZX = 8'h41;
    localparam logic [7:0] OP_EOR_IZY = 8'h51;

    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
    localparam logic [7:0] OP_LDA_ABS = 8'hAD;
    localparam logic [7:0] OP_LDA_ABX = 8'hBD;
    localparam logic [7:0] OP_LDA_ABY = 8'hB9;
    localparam logic [7:0] OP_LDA_IZX = 8'hA1;
    localparam logic [7:0] OP_LDA_IZY = 8'hB1;

    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
    localparam logic [7:0] OP_LDX_ZPY = 8'hB6;
    localparam logic [7:0] OP_LDX_ABS = 8'hAE;
    localparam logic [7:0] OP_LDX_ABY = 8'hBE;

    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
    localparam logic [7:0] OP_LDY_ZPX = 8'hB4;
    localparam logic [7:0] OP_LDY_ABS = 8'hAC;
    localparam logic [7:0] OP_LDY_ABX = 8'hBC;

    localparam logic [7:0] OP_TAX = 8'hAA;
    localparam logic [7:0] OP_TXA = 8'h8A;
    localparam logic [7:0] OP_TAY = 8'hA8;
    localparam logic [7:0] OP_TYA = 8'h98;
    localparam logic [7:0] OP_INX = 8'hE8;
    localparam logic [7:0] OP_DEX = 8'hCA;
    localparam logic [7:0] OP_INY = 8'hC8;
    localparam logic [7:0] OP_DEY = 8'h88;
    localparam logic [7:0] OP_TXS = 8'h9A;
    localparam logic [7:0] OP_TSX = 8'hBA;
    localparam logic [7:0] OP_CLC = 8'h18;
    localparam logic [7:0] OP_SEC = 8'h38;
    localparam logic [7:0] OP_CLI = 8'h58;
    localparam logic [7:0] OP_SEI = 8'h78;
    localparam logic [7:0] OP_CLV = 8'hB8;
    localparam logic [7:0] OP_CLD = 8'hD8;
    localparam logic [7:0] OP_SED = 8'hF8;
    localparam logic [7:0] OP_NOP = 8'hEA;

endpackage

FILE: hdl/cllt_exec.sv
// ============================================================================
// Instruction execute logic
// Decodes one opcode and computes the next architectural state and flags.
// ============================================================================
module cllt_exec
    import cllt_pkg::*;
(
    input  t_arch_state i_state,
    input  t_in_item    i_item,
    output t_arch_state o_state,
    output logic        o_unknown_op
);

    always_comb begin
        logic       nz_en;
        logic [7:0] nz_val;

        o_state      = i_state;
        o_unknown_op = 1'b0;
        nz_en        = 1'b0;
        nz_val       = '0;

        unique case (i_item.cmd) inside
            OP_ORA_IMM, OP_ORA_ZP, OP_ORA_ZPX, OP_ORA_ABS,
            OP_ORA_ABX, OP_ORA_ABY, OP_ORA_IZX, OP_ORA_IZY: begin
                o_state.acc = i_state.acc | i_item.operand;
                nz_en       = 1'b1;
                nz_val      = o_state.acc;
            end
            OP_AND_IMM, OP_AND_ZP, OP_AND_ZPX, OP_AND_ABS,
            OP_AND_ABX, OP_AND_ABY, OP_AND_IZX, OP_AND_IZY: begin
                o_state.acc = i_state.acc & i_item.operand;
                nz_en       = 1'b1;
                nz_val      = o_state.acc;
            end
            OP_EOR_IMM, OP_EOR_ZP, OP_EOR_ZPX, OP_EOR_ABS,
            OP_EOR_ABX, OP_EOR_ABY, OP_EOR_IZX, OP_EOR_IZY: begin
                o_state.acc = i_state.acc ^ i_item.operand;
                nz_en       = 1'b1;
                nz_val      = o_state.acc;
            end
            OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_ABS,
            OP_LDA_ABX, OP_LDA_ABY, OP_LDA_IZX, OP_LDA_IZY: begin
                o_state.acc = i_item.operand;
                nz_en       = 1'b1;
                nz_val      = i_item.operand;
            end
            OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ZPY, OP_LDX_ABS, OP_LDX_ABY: begin
                o_state.x = i_item.operand;
                nz_en     = 1'b1;
                nz_val    = i_item.operand;
            end
            OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ZPX, OP_LDY_ABS, OP_LDY_ABX: begin
                o_state.y = i_item.operand;
                nz_en     = 1'b1;
                nz_val    = i_item.operand;
            end
            OP_TAX: begin
                o_state.x = i_state.acc;
                nz_en     = 1'b1;
                nz_val    = i_state.acc;
            end
            OP_TXA: begin
                o_state.acc = i_state.x;
                nz_en       = 1'b1;
                nz_val      = i_state.x;
            end
            OP_TAY: begin
                o_state.y = i_state.acc;
                nz_en     = 1'b1;
                nz_val    = i_state.acc;
            end
            OP_TYA: begin
                o_state.acc = i_state.y;
                nz_en       = 1'b1;
                nz_val      = i_state.y;
            end
            OP_INX: begin
                o_state.x = i_state.x + 8'd1;
                nz_en     = 1'b1;
                nz_val    = o_state.x;
            end
            OP_DEX: begin
                o_state.x = i_state.x - 8'd1;
                nz_en     = 1'b1;
                nz_val    = o_state.x;
            end
            OP_INY: begin
                o_state.y = i_state.y + 8'd1;
                nz_en     = 1'b1;
                nz_val    = o_state.y;
            end
            OP_DEY: begin
                o_state.y = i_state.y - 8'd1;
                nz_en     = 1'b1;
                nz_val    = o_state.y;
            end
            OP_TXS: begin
                o_state.sp = i_state.x;
            end
            OP_TSX: begin
                o_state.x = i_state.sp;
                nz_en     = 1'b1;
                nz_val    = i_state.sp;
            end
            OP_CLC: o_state.status[FLAG_C] = 1'b0;
            OP_SEC: o_state.status[FLAG_C] = 1'b1;
            OP_CLI: o_state.status[FLAG_I] = 1'b0;
            OP_SEI: o_state.status[FLAG_I] = 1'b1;
            OP_CLV: o_state.status[FLAG_V] = 1'b0;
            OP_CLD: o_state.status[FLAG_D] = 1'b0;
            OP_SED: o_state.status[FLAG_D] = 1'b1;
            OP_NOP: begin
                o_state = i_state;
            end
            default: begin
                o_unknown_op = 1'b1;
            end
        endcase

        if (nz_en) begin
            o_state.status[FLAG_N] = nz_val[7];
            o_state.status[FLAG_Z] = (nz_val == 8'd0);
        end
    end

endmodule

FILE: hdl/cpu_logic_load_transfer_unit.sv
// ============================================================================
// Load, logic and transfer unit
// Executes one load, logic, transfer or flag instruction per transaction.
// ============================================================================
// Usage:
// The input channel carries an opcode and the operand byte already fetched by
// its addressing mode. Each input transaction produces exactly one output
// transaction holding A, X, Y, the status byte, the stack pointer and a flag
// that marks an opcode this unit does not handle.
// A transaction is taken into an input register, executed against the
// architectural registers once the output register is free or being
// emptied, and its result placed in the output register.
// One instruction per cycle is sustained while the receiver does not stall;
// the limit is the single execute stage, which reads and writes A, X, Y,
// status and the stack pointer.
// The receiver may stall at any time. The output register then holds its
// result, the execute stage waits and the input register fills, after which
// the input channel stalls as well. No transaction is lost or repeated.
// Reset clears A, X, Y and status, sets the stack pointer to 0xFF and
// empties both pipeline registers.
// ============================================================================
module cpu_logic_load_transfer_unit
    import cllt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

`include "cpu_logic_load_transfer_unit_assert.svh"

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_arch_state r_state;

    t_arch_state n_state;
    logic        exec_unknown;
    logic        exec_fire;
    logic        in_accept;

    cllt_exec u_exec (
        .i_state      (r_state),
        .i_item       (r_in),
        .o_state      (n_state),
        .o_unknown_op (exec_unknown)
    );

    assign exec_fire  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !exec_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (exec_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.acc    <= 8'd0;
            r_state.x      <= 8'd0;
            r_state.y      <= 8'd0;
            r_state.status <= 8'd0;
            r_state.sp     <= SP_RESET;
        end else if (exec_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out.acc        <= n_state.acc;
            r_out.index_x    <= n_state.x;
            r_out.index_y    <= n_state.y;
            r_out.status     <= n_state.status;
            r_out.stack_ptr  <= n_state.sp;
            r_out.unknown_op <= exec_unknown;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CLLT_ASSERT_NEXT(a_state_idle_hold, i_clk, i_rst_n, !exec_fire, $stable(r_state))
    `CLLT_ASSERT_NEXT(a_unknown_no_change, i_clk, i_rst_n,
        exec_fire && exec_unknown, $stable(r_state))
    `CLLT_ASSERT_NOW(a_out_tracks_state, i_clk, i_rst_n, r_out_valid,
        (r_out.acc == r_state.acc) && (r_out.index_x == r_state.x) &&
        (r_out.index_y == r_state.y) && (r_out.status == r_state.status) &&
        (r_out.stack_ptr == r_state.sp))
    `CLLT_ASSERT_NEXT(a_in_item_kept, i_clk, i_rst_n, r_in_valid && !exec_fire, r_in_valid && $stable(r_in))

endmodule
